// ----- src/first_fit_extent_allocator_top_macros.svh -----
// ----------------------------------------------------------------------------
// first_fit_extent_allocator_top_macros.svh
// Assertion macros used by the extent allocator controller (ffea_ctrl).
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define FFEA_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define FFEA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FFEA_ASSERT(label, clk, rst_n, expr)
`define FFEA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/ffea_pkg.sv -----
// ----------------------------------------------------------------------------
// ffea_pkg
// Types and constants of the first-fit extent allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffea_pkg;

    localparam int MAX_EXTENTS_DEF = 64;
    localparam int ADDR_BITS       = 31;
    localparam int IDX_W_MAX       = 10;
    localparam logic [31:0] HEAP_RESET = 32'd65536;
    localparam logic [31:0] HEAP_LIMIT = 32'(64'd1 << ADDR_BITS);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SIZE = 2'd1,
        ST_NO_FIT   = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic {
        FN_ALLOC = 1'b0,
        FN_FREE  = 1'b1
    } func_t;

    typedef struct packed {
        logic        func;
        logic [31:0] req_size;
        logic [22:0] align_bytes;
        logic [30:0] free_start;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [30:0] aln_start;
        logic [30:0] alloc_start;
        logic [31:0] alloc_size;
        logic        heap_in_use;
    } rsp_t;

    typedef struct packed {
        logic [30:0] base;
        logic [31:0] len;
    } ext_t;

    typedef struct packed {
        logic                 rd_en;
        logic [IDX_W_MAX-1:0] rd_addr;
        logic                 wr_en;
        logic [IDX_W_MAX-1:0] wr_addr;
        ext_t                 wr_data;
    } mem_cmd_t;

    typedef struct packed {
        logic        wr;
        logic [31:0] heap;
    } cfg_t;

endpackage

`default_nettype wire

// ----- src/ffea_extent_mem.sv -----
// ----------------------------------------------------------------------------
// ffea_extent_mem
// Extent table: one write and one registered read per cycle. Entry 0 reads
// as the whole heap until it is first written after a list reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ffea_extent_mem #(
    parameter int MAX_EXTENTS = ffea_pkg::MAX_EXTENTS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              clear,
    input  wire logic [31:0]       heap,
    input  wire ffea_pkg::mem_cmd_t cmd,
    output ffea_pkg::ext_t         rd_data
);
    import ffea_pkg::*;

    localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;

    ext_t mem [MAX_EXTENTS];
    ext_t q_reg;
    logic e0_init_reg;
    logic ovr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr[IW-1:0]] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            q_reg <= mem[cmd.rd_addr[IW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e0_init_reg <= 1'b1;
            ovr_reg     <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                e0_init_reg <= 1'b1;
            end
            else if (cmd.wr_en && cmd.wr_addr[IW-1:0] == '0)
            begin
                e0_init_reg <= 1'b0;
            end
            if (cmd.rd_en)
            begin
                ovr_reg <= e0_init_reg && (cmd.rd_addr[IW-1:0] == '0);
            end
        end
    end

    assign rd_data = ovr_reg ? ext_t'{base: '0, len: heap} : q_reg;

endmodule

`default_nettype wire

// ----- src/ffea_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffea_ctrl
// Request sequencer: scans the extent table, updates it in place and shifts
// entries on insert and remove.
// ----------------------------------------------------------------------------
`default_nettype none

`include "first_fit_extent_allocator_top_macros.svh"

module ffea_ctrl #(
    parameter int MAX_EXTENTS = ffea_pkg::MAX_EXTENTS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ffea_pkg::cfg_t     cfg,
    input  wire logic [31:0]        heap,
    input  wire logic               start,
    input  wire ffea_pkg::req_t     req,
    output logic                    busy,
    output logic                    done,
    output ffea_pkg::rsp_t          rsp,
    output ffea_pkg::mem_cmd_t      mem_cmd,
    input  wire ffea_pkg::ext_t     mem_rd
);
    import ffea_pkg::*;

    localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_EXTENTS);
    localparam logic [CW-1:0] ONE     = CW'(1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RD   = 8'b0000_0010,
        S_CHK  = 8'b0000_0100,
        S_FDEC = 8'b0000_1000,
        S_SHRD = 8'b0001_0000,
        S_SHWR = 8'b0010_0000,
        S_WR   = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] ins_reg, ins_next;
    logic [31:0]   len0_reg, len0_next;
    logic          have_prev_reg, have_prev_next;
    logic          down_reg, down_next;
    logic          op_reg, op_next;
    logic [31:0]   size_reg, size_next;
    logic [30:0]   fstart_reg, fstart_next;
    logic [22:0]   mask_reg, mask_next;
    ext_t          prev_reg, prev_next;
    ext_t          nxt_reg, nxt_next;
    status_t       status_reg, status_next;
    logic [30:0]   aligned_reg, aligned_next;
    logic [30:0]   astart_reg, astart_next;
    logic [31:0]   asize_reg, asize_next;

    logic [4:0]  msb;
    logic [22:0] in_mask;
    logic        in_bad;
    logic [32:0] in_end;
    logic [31:0] al_pos;
    logic [32:0] ext_end;
    logic        fit;
    logic [31:0] new_base;
    logic [31:0] taken;
    logic [31:0] new_len;
    logic        left;
    logic        right;
    logic [32:0] free_end;
    logic [32:0] prev_end;

    always_comb
    begin
        msb = '0;
        for (int i = 0; i < 23; i++)
        begin
            if (req.align_bytes[i])
            begin
                msb = 5'(i);
            end
        end
        in_mask = 23'((24'd1 << msb) - 24'd1);
        in_end  = {2'b0, req.free_start} + {1'b0, req.req_size};
        if (req.func == FN_ALLOC)
        begin
            in_bad = (req.req_size == '0) || (req.req_size > heap);
        end
        else
        begin
            in_bad = (req.req_size == '0) || (in_end > {1'b0, heap});
        end
    end

    always_comb
    begin
        al_pos   = ({1'b0, mem_rd.base} + {9'b0, mask_reg}) & ~{9'b0, mask_reg};
        ext_end  = {2'b0, mem_rd.base} + {1'b0, mem_rd.len};
        fit      = (mem_rd.len >= size_reg)
                   && (({1'b0, al_pos} + {1'b0, size_reg}) <= ext_end);
        new_base = al_pos + size_reg;
        taken    = new_base - {1'b0, mem_rd.base};
        new_len  = 32'(ext_end - {1'b0, new_base});
        free_end = {2'b0, fstart_reg} + {1'b0, size_reg};
        prev_end = {2'b0, prev_reg.base} + {1'b0, prev_reg.len};
        left     = have_prev_reg && (prev_end == {2'b0, fstart_reg});
        right    = (ins_reg < cnt_reg) && (free_end == {2'b0, nxt_reg.base});
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        ins_next       = ins_reg;
        len0_next      = len0_reg;
        have_prev_next = have_prev_reg;
        down_next      = down_reg;
        op_next        = op_reg;
        size_next      = size_reg;
        fstart_next    = fstart_reg;
        mask_next      = mask_reg;
        prev_next      = prev_reg;
        nxt_next       = nxt_reg;
        status_next    = status_reg;
        aligned_next   = aligned_reg;
        astart_next    = astart_reg;
        asize_next     = asize_reg;
        mem_cmd        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next        = req.func;
                    size_next      = req.req_size;
                    fstart_next    = req.free_start;
                    mask_next      = in_mask;
                    idx_next       = '0;
                    have_prev_next = 1'b0;
                    aligned_next   = '0;
                    astart_next    = '0;
                    asize_next     = '0;
                    status_next    = ST_OK;
                    if (in_bad)
                    begin
                        status_next = ST_BAD_SIZE;
                        state_next  = S_DONE;
                    end
                    else if (cnt_reg == '0)
                    begin
                        if (req.func == FN_ALLOC)
                        begin
                            status_next = ST_NO_FIT;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            ins_next   = '0;
                            state_next = S_FDEC;
                        end
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                mem_cmd.rd_en   = 1'b1;
                mem_cmd.rd_addr = IDX_W_MAX'(idx_reg[IW-1:0]);
                state_next      = S_CHK;
            end
            S_CHK:
            begin
                if (op_reg == FN_ALLOC)
                begin
                    if (fit)
                    begin
                        aligned_next = al_pos[30:0];
                        astart_next  = mem_rd.base;
                        asize_next   = taken;
                        if (new_len == '0)
                        begin
                            if (CW'(idx_reg + ONE) < cnt_reg)
                            begin
                                idx_next   = CW'(idx_reg + ONE);
                                down_next  = 1'b1;
                                state_next = S_SHRD;
                            end
                            else
                            begin
                                cnt_next   = CW'(cnt_reg - ONE);
                                state_next = S_DONE;
                            end
                        end
                        else
                        begin
                            mem_cmd.wr_en   = 1'b1;
                            mem_cmd.wr_addr = IDX_W_MAX'(idx_reg[IW-1:0]);
                            mem_cmd.wr_data = ext_t'{base: new_base[30:0], len: new_len};
                            if (idx_reg == '0)
                            begin
                                len0_next = new_len;
                            end
                            state_next = S_DONE;
                        end
                    end
                    else if (CW'(idx_reg + ONE) == cnt_reg)
                    begin
                        status_next = ST_NO_FIT;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        idx_next   = CW'(idx_reg + ONE);
                        state_next = S_RD;
                    end
                end
                else
                begin
                    if (fstart_reg < mem_rd.base)
                    begin
                        ins_next   = idx_reg;
                        nxt_next   = mem_rd;
                        state_next = S_FDEC;
                    end
                    else
                    begin
                        prev_next      = mem_rd;
                        have_prev_next = 1'b1;
                        if (CW'(idx_reg + ONE) == cnt_reg)
                        begin
                            ins_next   = cnt_reg;
                            state_next = S_FDEC;
                        end
                        else
                        begin
                            idx_next   = CW'(idx_reg + ONE);
                            state_next = S_RD;
                        end
                    end
                end
            end
            S_FDEC:
            begin
                if (left)
                begin
                    mem_cmd.wr_en   = 1'b1;
                    mem_cmd.wr_addr = IDX_W_MAX'(CW'(ins_reg - ONE));
                    mem_cmd.wr_data.base = prev_reg.base;
                    mem_cmd.wr_data.len  = right ? (prev_reg.len + size_reg + nxt_reg.len)
                                                 : (prev_reg.len + size_reg);
                    if (ins_reg == ONE)
                    begin
                        len0_next = mem_cmd.wr_data.len;
                    end
                    if (!right)
                    begin
                        state_next = S_DONE;
                    end
                    else if (CW'(ins_reg + ONE) < cnt_reg)
                    begin
                        idx_next   = CW'(ins_reg + ONE);
                        down_next  = 1'b1;
                        state_next = S_SHRD;
                    end
                    else
                    begin
                        cnt_next   = CW'(cnt_reg - ONE);
                        state_next = S_DONE;
                    end
                end
                else if (right)
                begin
                    mem_cmd.wr_en   = 1'b1;
                    mem_cmd.wr_addr = IDX_W_MAX'(ins_reg[IW-1:0]);
                    mem_cmd.wr_data = ext_t'{base: fstart_reg, len: nxt_reg.len + size_reg};
                    if (ins_reg == '0)
                    begin
                        len0_next = mem_cmd.wr_data.len;
                    end
                    state_next = S_DONE;
                end
                else if (cnt_reg >= CNT_MAX)
                begin
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end
                else if (cnt_reg > ins_reg)
                begin
                    idx_next   = CW'(cnt_reg - ONE);
                    down_next  = 1'b0;
                    state_next = S_SHRD;
                end
                else
                begin
                    state_next = S_WR;
                end
            end
            S_SHRD:
            begin
                mem_cmd.rd_en   = 1'b1;
                mem_cmd.rd_addr = IDX_W_MAX'(idx_reg[IW-1:0]);
                state_next      = S_SHWR;
            end
            S_SHWR:
            begin
                mem_cmd.wr_en   = 1'b1;
                mem_cmd.wr_data = mem_rd;
                if (down_reg)
                begin
                    mem_cmd.wr_addr = IDX_W_MAX'(CW'(idx_reg - ONE));
                    if (idx_reg == ONE)
                    begin
                        len0_next = mem_rd.len;
                    end
                    if (CW'(idx_reg + ONE) < cnt_reg)
                    begin
                        idx_next   = CW'(idx_reg + ONE);
                        state_next = S_SHRD;
                    end
                    else
                    begin
                        cnt_next   = CW'(cnt_reg - ONE);
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    mem_cmd.wr_addr = IDX_W_MAX'(CW'(idx_reg + ONE));
                    if (idx_reg == ins_reg)
                    begin
                        state_next = S_WR;
                    end
                    else
                    begin
                        idx_next   = CW'(idx_reg - ONE);
                        state_next = S_SHRD;
                    end
                end
            end
            S_WR:
            begin
                mem_cmd.wr_en   = 1'b1;
                mem_cmd.wr_addr = IDX_W_MAX'(ins_reg[IW-1:0]);
                mem_cmd.wr_data = ext_t'{base: fstart_reg, len: size_reg};
                if (ins_reg == '0)
                begin
                    len0_next = size_reg;
                end
                cnt_next   = CW'(cnt_reg + ONE);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg.wr)
        begin
            cnt_next  = ONE;
            len0_next = cfg.heap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= ONE;
            len0_reg      <= HEAP_RESET;
            have_prev_reg <= 1'b0;
            down_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            len0_reg      <= len0_next;
            have_prev_reg <= have_prev_next;
            down_reg      <= down_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        ins_reg     <= ins_next;
        op_reg      <= op_next;
        size_reg    <= size_next;
        fstart_reg  <= fstart_next;
        mask_reg    <= mask_next;
        prev_reg    <= prev_next;
        nxt_reg     <= nxt_next;
        status_reg  <= status_next;
        aligned_reg <= aligned_next;
        astart_reg  <= astart_next;
        asize_reg   <= asize_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    always_comb
    begin
        rsp.status      = status_reg;
        rsp.aln_start   = aligned_reg;
        rsp.alloc_start = astart_reg;
        rsp.alloc_size  = asize_reg;
        rsp.heap_in_use = (cnt_reg != ONE) || (len0_reg != heap);
    end

    `FFEA_ASSERT(a_cnt_bound, clk, rst_n, cnt_reg <= CNT_MAX)
    `FFEA_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done && !busy)
    `FFEA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `FFEA_ASSERT_NEXT(a_fail_keeps_cnt, clk, rst_n,
        busy && !done && !cfg.wr && status_next != ST_OK, cnt_reg == $past(cnt_reg))

endmodule

`default_nettype wire

// ----- src/first_fit_extent_allocator_top.sv -----
// ----------------------------------------------------------------------------
// first_fit_extent_allocator_top
// First-fit heap allocator over an address-sorted table of free extents.
// ----------------------------------------------------------------------------
//  channel   | signals                         | handshake
//  ----------+---------------------------------+-------------------------------
//  request   | start, busy, req                | taken when start && !busy
//  result    | done, rsp                       | one-cycle strobe, no backpressure
//  config    | psel penable pwrite paddr pwdata| APB, pready tied high
//
//  A request reads and checks each extent of the scan (S_RD, S_CHK), decides
//  a free in S_FDEC, reads then writes each entry shifted on insert or remove
//  (S_SHRD, S_SHWR), writes an insert in S_WR and ends with the done strobe
//  in S_DONE; it then returns to S_IDLE before the next request is taken.
//  rst_n clears the list to one extent covering a 64 KiB heap; no clearing
//  pass runs. Any APB write, whatever its paddr, does the same with the new
//  size, clamped to HEAP_LIMIT.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_extent_allocator_top #(
    parameter int MAX_EXTENTS = ffea_pkg::MAX_EXTENTS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [1:0]      paddr,
    input  wire logic [31:0]     pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  wire logic            start,
    input  wire ffea_pkg::req_t  req,
    output logic                 busy,
    output logic                 done,
    output ffea_pkg::rsp_t       rsp
);
    import ffea_pkg::*;

    logic [31:0] heap_reg;
    cfg_t        cfg;
    mem_cmd_t    mem_cmd;
    ext_t        mem_rd;

    assign pready   = 1'b1;
    assign cfg.wr   = psel && penable && pwrite;
    assign cfg.heap = (pwdata > HEAP_LIMIT) ? HEAP_LIMIT : pwdata;
    assign prdata   = (paddr == 2'd0) ? heap_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_reg <= HEAP_RESET;
        end
        else if (cfg.wr)
        begin
            heap_reg <= cfg.heap;
        end
    end

    ffea_extent_mem #(
        .MAX_EXTENTS (MAX_EXTENTS)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (cfg.wr),
        .heap    (heap_reg),
        .cmd     (mem_cmd),
        .rd_data (mem_rd)
    );

    ffea_ctrl #(
        .MAX_EXTENTS (MAX_EXTENTS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .heap    (heap_reg),
        .start   (start),
        .req     (req),
        .busy    (busy),
        .done    (done),
        .rsp     (rsp),
        .mem_cmd (mem_cmd),
        .mem_rd  (mem_rd)
    );

endmodule

`default_nettype wire
